// ----- hw/rtl/kts_pkg.sv -----
// Shared types, constants and helpers for the keyframe timing sequencer.
// No dependencies; used by the top level and its checker.
package kts_pkg;

    localparam int MAX_FRAMES = 16;
    localparam int MAX_STEPS  = 16;

    localparam int FRAME_W   = 4;
    localparam int CNT_W     = 5;
    localparam int SPEED_W   = 12;
    localparam int TIME_W    = 16;
    localparam int ELAPSED_W = 24;
    localparam int FRAC_W    = 8;
    localparam int PROD_W    = TIME_W + SPEED_W;
    localparam int STEP_W    = $clog2(MAX_STEPS + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 8;

    // output beat field positions
    localparam int OUT_FRM_LO = 0;
    localparam int OUT_VALID  = 4;
    localparam int OUT_HALTED = 5;
    localparam int OUT_REJ    = 6;
    localparam int OUT_OVF    = 7;

    typedef logic [FRAME_W-1:0]   t_frame;
    typedef logic [CNT_W-1:0]     t_count;
    typedef logic [ELAPSED_W-1:0] t_elapsed;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_GOTO  = 2'd2
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_COUNT = 2'd0,
        CFG_SPEED       = 2'd1,
        CFG_FORWARD     = 2'd2
    } t_cfg_reg;

    function automatic t_count count_in_effect(t_count fc);
        return (fc < CNT_W'(MAX_FRAMES)) ? fc : CNT_W'(MAX_FRAMES);
    endfunction

    function automatic t_frame neighbor(t_frame f, t_count n, logic fwd);
        t_count f5;
        f5 = {1'b0, f};
        if (n == '0) begin
            return '0;
        end
        if (fwd) begin
            if (f5 + CNT_W'(1) >= n) begin
                return '0;
            end
            return f + FRAME_W'(1);
        end
        if (f == '0 || f5 >= n) begin
            return FRAME_W'(n - CNT_W'(1));
        end
        return f - FRAME_W'(1);
    endfunction

endpackage

// ----- hw/rtl/keyframe_timing_sequencer.sv -----
// Keyframe timing sequencer: frame table, elapsed-time accumulator and
// advance sequencer around one shared 24-bit compare/subtract unit.
// Depends on kts_pkg.

// A table write stays in ST_IDLE; a goto passes through ST_GOTO (if in
// range) and ST_FINISH. A tick that plays on scales and accumulates its
// delta in ST_ADD, then makes up to MAX_STEPS frame advances, each in
// ST_CHECK (compare/subtract of the elapsed time against the wait) and
// ST_ENTER (table lookup of the entered frame), closes in ST_CHECK and,
// when it entered a frame, issues its final result in ST_FINISH; a tick
// that does not play stays in ST_IDLE. All advances share the single
// compare/subtract unit. Waits on i_m_tready hold ST_FINISH and the
// advances that follow an entry. The next beat is taken while the final
// result of the previous one still sits in the output register.
module keyframe_timing_sequencer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input beats
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [15:0] delta_time, [19:16] frame_index, [35:20] entry_wait,
    // [36] entry_jump_enable, [40:37] entry_jump_target, [41] entry_stop
    input  logic [kts_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // [1:0] opcode
    input  logic [1:0]                        i_s_tuser,
    // result beats
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [3:0] frame_entered, [4] entered_valid, [5] halted,
    // [6] rejected, [7] step_overflow
    output logic [kts_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    output logic                              o_m_tlast,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [kts_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [kts_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_ADD    = 6'b000010,
        ST_CHECK  = 6'b000100,
        ST_ENTER  = 6'b001000,
        ST_GOTO   = 6'b010000,
        ST_FINISH = 6'b100000
    } t_state;

    t_state r_state;

    kts_pkg::t_count                   r_frame_count;
    logic [kts_pkg::SPEED_W-1:0]       r_speed;
    logic                              r_forward;

    logic [kts_pkg::TIME_W-1:0]        r_wait [kts_pkg::MAX_FRAMES];
    logic                              r_je   [kts_pkg::MAX_FRAMES];
    kts_pkg::t_frame                   r_jt   [kts_pkg::MAX_FRAMES];
    logic                              r_stop [kts_pkg::MAX_FRAMES];

    kts_pkg::t_frame                   r_cur;
    kts_pkg::t_frame                   r_next;
    logic                              r_cur_valid;
    kts_pkg::t_elapsed                 r_elapsed;
    logic                              r_active;
    logic [kts_pkg::TIME_W-1:0]        r_delta;
    logic [kts_pkg::STEP_W-1:0]        r_k;
    logic                              r_have;

    kts_pkg::t_frame                   r_pend_frm;
    logic                              r_pend_valid;
    logic                              r_pend_halt;
    logic                              r_pend_rej;
    logic                              r_ovf;

    logic                              r_out_valid;
    logic [kts_pkg::OUT_DATA_W-1:0]    r_out_data;
    logic                              r_out_last;

    kts_pkg::t_opcode                  w_op;
    kts_pkg::t_frame                   w_idx;
    kts_pkg::t_count                   w_cnt;
    logic                              w_in_acc;
    logic                              w_out_free;
    logic [kts_pkg::PROD_W-1:0]        w_prod;
    logic [kts_pkg::PROD_W:0]          w_sum;
    kts_pkg::t_elapsed                 n_elapsed_acc;
    kts_pkg::t_elapsed                 w_wait_q;
    logic                              w_gt;
    logic                              w_check_done;
    logic                              w_load;
    logic                              w_load_last;
    kts_pkg::t_frame                   w_adv_frame;
    logic                              n_active_enter;
    logic                              n_active_goto;
    logic [kts_pkg::OUT_DATA_W-1:0]    w_pend_beat;

    assign w_op       = kts_pkg::t_opcode'(i_s_tuser);
    assign w_idx      = i_s_tdata[19:16];
    assign w_cnt      = kts_pkg::count_in_effect(r_frame_count);
    assign o_s_tready = (r_state == ST_IDLE);
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_cfg_ready = 1'b1;

    assign w_prod = kts_pkg::PROD_W'(r_delta) * kts_pkg::PROD_W'(r_speed);
    assign w_sum  = (kts_pkg::PROD_W + 1)'(r_elapsed) + (kts_pkg::PROD_W + 1)'(w_prod);
    assign n_elapsed_acc = (w_sum[kts_pkg::PROD_W:kts_pkg::ELAPSED_W] != '0) ? '1
                         : w_sum[kts_pkg::ELAPSED_W-1:0];

    // shared compare/subtract against the current frame's wait
    assign w_wait_q = {r_wait[r_cur], kts_pkg::FRAC_W'(0)};
    assign w_gt     = r_elapsed > w_wait_q;
    assign w_adv_frame = ({1'b0, r_next} < w_cnt) ? r_next : '0;
    assign w_check_done = !w_gt || !r_active
                        || r_k == kts_pkg::STEP_W'(kts_pkg::MAX_STEPS);

    // output register load: pending entry mid-run, or the final beat
    assign w_load = ((r_state == ST_CHECK) && !w_check_done && r_have && w_out_free)
                 || ((r_state == ST_FINISH) && w_out_free);
    assign w_load_last = (r_state == ST_FINISH);

    assign n_active_enter = r_active && !r_stop[r_cur];
    assign n_active_goto  = n_active_enter;
    assign w_pend_beat = {1'b0, r_pend_rej, r_pend_halt, r_pend_valid, r_pend_frm};

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    // frame table
    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_op == kts_pkg::OP_WRITE
            && {1'b0, w_idx} < kts_pkg::CNT_W'(kts_pkg::MAX_FRAMES)) begin
            r_wait[w_idx] <= i_s_tdata[35:20];
            r_je[w_idx]   <= i_s_tdata[36];
            r_jt[w_idx]   <= i_s_tdata[40:37];
            r_stop[w_idx] <= i_s_tdata[41];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= kts_pkg::CNT_W'(1);
            r_speed       <= kts_pkg::SPEED_W'(256);
            r_forward     <= 1'b1;
        end else if (i_cfg_valid) begin
            case (kts_pkg::t_cfg_reg'(i_cfg_index))
                kts_pkg::CFG_FRAME_COUNT: r_frame_count <= i_cfg_data[kts_pkg::CNT_W-1:0];
                kts_pkg::CFG_SPEED:       r_speed       <= i_cfg_data;
                kts_pkg::CFG_FORWARD:     r_forward     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // result output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
            r_out_data  <= w_load_last ? {r_ovf, w_pend_beat[kts_pkg::OUT_DATA_W-2:0]}
                                       : w_pend_beat;
            r_out_last  <= w_load_last;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cur       <= '0;
            r_next      <= '0;
            r_cur_valid <= 1'b0;
            r_elapsed   <= '0;
            r_active    <= 1'b1;
            r_k         <= '0;
            r_have      <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        case (w_op)
                            kts_pkg::OP_TICK: begin
                                if (r_active && r_cur_valid && {1'b0, r_cur} < w_cnt) begin
                                    r_delta <= i_s_tdata[15:0];
                                    r_state <= ST_ADD;
                                end
                            end
                            kts_pkg::OP_GOTO: begin
                                if ({1'b0, w_idx} < w_cnt) begin
                                    r_cur       <= w_idx;
                                    r_cur_valid <= 1'b1;
                                    r_state     <= ST_GOTO;
                                end else begin
                                    r_pend_frm   <= '0;
                                    r_pend_valid <= 1'b0;
                                    r_pend_halt  <= !r_active;
                                    r_pend_rej   <= 1'b1;
                                    r_ovf        <= 1'b0;
                                    r_state      <= ST_FINISH;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_ADD: begin
                    r_elapsed <= n_elapsed_acc;
                    r_k       <= '0;
                    r_have    <= 1'b0;
                    r_state   <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (w_check_done) begin
                        if (w_gt && !r_active) begin
                            r_elapsed <= '0;
                        end
                        r_ovf   <= w_gt && r_active;
                        r_state <= r_have ? ST_FINISH : ST_IDLE;
                    end else if (!r_have || w_out_free) begin
                        r_elapsed <= r_elapsed - w_wait_q;
                        r_cur     <= w_adv_frame;
                        r_next    <= kts_pkg::neighbor(r_next, w_cnt, r_forward);
                        r_state   <= ST_ENTER;
                    end
                end
                ST_ENTER: begin
                    if (r_je[r_cur] && {1'b0, r_jt[r_cur]} < w_cnt) begin
                        r_next <= r_jt[r_cur];
                    end
                    r_active     <= n_active_enter;
                    r_pend_frm   <= r_cur;
                    r_pend_valid <= 1'b1;
                    r_pend_halt  <= !n_active_enter;
                    r_pend_rej   <= 1'b0;
                    r_k          <= r_k + kts_pkg::STEP_W'(1);
                    r_have       <= 1'b1;
                    r_state      <= ST_CHECK;
                end
                ST_GOTO: begin
                    r_active     <= n_active_goto;
                    r_next       <= kts_pkg::neighbor(r_cur, w_cnt, r_forward);
                    r_pend_frm   <= r_cur;
                    r_pend_valid <= 1'b1;
                    r_pend_halt  <= !n_active_goto;
                    r_pend_rej   <= 1'b0;
                    r_ovf        <= 1'b0;
                    r_state      <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- hw/rtl/kts_checker.sv -----
// Port-level checks for the keyframe timing sequencer, bound to the top level.
// Depends on kts_pkg and keyframe_timing_sequencer.
module kts_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_s_tready,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [kts_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input logic                           o_m_tlast
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result beat right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled result beat changed");

    a_reject_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[kts_pkg::OUT_REJ] |->
            !o_m_tdata[kts_pkg::OUT_VALID] && o_m_tdata[3:0] == 4'd0 && o_m_tlast)
        else $error("rejected goto beat malformed");

    a_ovf_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[kts_pkg::OUT_OVF] |->
            o_m_tlast && o_m_tdata[kts_pkg::OUT_VALID])
        else $error("step overflow off the final frame entry");

    a_busy_midrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> !o_s_tready)
        else $error("input taken while a tick run is open");

endmodule

bind keyframe_timing_sequencer kts_checker u_kts_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
